// File: src/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants of the lossless predictor residual block.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned PIX_W  = 3 * CH_W;
  localparam int unsigned RW_W   = 13;
  localparam int unsigned PS_W   = 3;
  localparam int unsigned CFG_AW = 1;
  localparam int unsigned CFG_DW = RW_W;

  typedef enum logic [PS_W-1:0] {
    PRED_W      = 3'd0,
    PRED_N      = 3'd1,
    PRED_NW     = 3'd2,
    PRED_GRAD   = 3'd3,
    PRED_N_HALF = 3'd4,
    PRED_W_HALF = 3'd5,
    PRED_AVG    = 3'd6,
    PRED_MED    = 3'd7
  } pred_sel_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_ROW_WIDTH   = 1'b0,
    REG_PRED_SELECT = 1'b1
  } cfg_reg_t;

  typedef logic [CH_W-1:0] chan_t;

endpackage

// File: src/lossless_predictor_residual_top.sv
// ----------------------------------------------------------------------------
// lossless_predictor_residual_top
// Per-channel modulo-256 residuals of an RGB raster stream against one of
// eight selectable W/N/NW predictors, with a line buffer for the row above.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  tdata red,green,blue; tuser frame_start
//   m_*       out        m_tvalid/m_tready  tdata red,green,blue residuals
//   cfg_*     in         cfg_we             cfg_addr register, cfg_data value
//
// One item per cycle sustained while m_tready allows; an accepted item passes
// the line buffer read, then the output register.
// rst clears position, neighbors and both stages; row_width resets to the
// maximum, predictor_select to the median edge detector.
// s_tready drops only while both stages hold items and m_tready is low.
// ----------------------------------------------------------------------------
module lossless_predictor_residual_top
  import lpr_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [PIX_W-1:0]  s_tdata,   // red_in, green_in, blue_in
  input  logic              s_tuser,   // frame_start
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [PIX_W-1:0]  m_tdata,   // red_residual, green_residual, blue_residual
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int unsigned CW = $clog2(MAX_ROW_WIDTH);
  localparam int unsigned EW = (CW + 1 > RW_W) ? CW + 1 : RW_W;

  logic [EW-1:0]    row_width;
  pred_sel_t        pred_sel;

  logic [CW-1:0]    col_pos;
  logic             first_row;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic [CW-1:0]    s1_col;
  logic             s1_first;
  logic             s1_hit;
  logic [PIX_W-1:0] s1_byp;

  logic [PIX_W-1:0] left_pix;
  logic [PIX_W-1:0] upleft_pix;

  logic             out_valid;
  logic [PIX_W-1:0] out_data;

  logic             accept;
  logic             adv1;
  logic [CW-1:0]    col_cur;
  logic             first_cur;
  logic [EW-1:0]    rw_eff;
  logic             row_last;
  logic [PIX_W-1:0] rd_data;
  logic [PIX_W-1:0] above;
  logic [PIX_W-1:0] n_pix;
  logic [PIX_W-1:0] w_pix;
  logic [PIX_W-1:0] nw_pix;
  logic [PIX_W-1:0] pred_pix;
  logic [PIX_W-1:0] resid;

  assign adv1     = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || adv1;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    col_cur   = s_tuser ? '0 : col_pos;
    first_cur = s_tuser || first_row;
    if (row_width == '0) begin
      rw_eff = EW'(1);
    end else if (row_width > EW'(MAX_ROW_WIDTH)) begin
      rw_eff = EW'(MAX_ROW_WIDTH);
    end else begin
      rw_eff = row_width;
    end
    row_last = (EW'(col_cur) + EW'(1)) >= rw_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= EW'(MAX_ROW_WIDTH);
      pred_sel  <= PRED_MED;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ROW_WIDTH:   row_width <= EW'(cfg_data);
        REG_PRED_SELECT: pred_sel  <= pred_sel_t'(cfg_data[PS_W-1:0]);
        default:         row_width <= row_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos   <= '0;
      first_row <= 1'b1;
    end else if (accept) begin
      col_pos   <= row_last ? '0 : col_cur + CW'(1);
      first_row <= row_last ? 1'b0 : first_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  // forward the pixel being written when it lands on the address read now
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= s_tdata;
      s1_col   <= col_cur;
      s1_first <= first_cur;
      s1_hit   <= adv1 && (s1_col == col_cur);
      s1_byp   <= s1_pix;
    end
  end

  lpr_line_buf #(
    .DEPTH (MAX_ROW_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (rd_data),
    .wr_en   (adv1),
    .wr_addr (s1_col),
    .wr_data (s1_pix)
  );

  always_comb begin
    above  = s1_hit ? s1_byp : rd_data;
    n_pix  = s1_first ? '0 : above;
    w_pix  = (s1_col == '0) ? '0 : left_pix;
    nw_pix = ((s1_col == '0) || s1_first) ? '0 : upleft_pix;
  end

  for (genvar k = 0; k < 3; k++) begin : g_chan
    lpr_predict u_predict (
      .n    (n_pix[k*CH_W +: CH_W]),
      .w    (w_pix[k*CH_W +: CH_W]),
      .nw   (nw_pix[k*CH_W +: CH_W]),
      .sel  (pred_sel),
      .pred (pred_pix[k*CH_W +: CH_W])
    );
    assign resid[k*CH_W +: CH_W] = s1_pix[k*CH_W +: CH_W] - pred_pix[k*CH_W +: CH_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pix   <= '0;
      upleft_pix <= '0;
    end else if (adv1) begin
      left_pix   <= s1_pix;
      upleft_pix <= above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      out_data <= resid;
    end
  end

endmodule

// File: src/lpr_predict.sv
// ----------------------------------------------------------------------------
// lpr_predict
// Prediction of one color channel from its W, N and NW neighbors.
// ----------------------------------------------------------------------------
module lpr_predict
  import lpr_pkg::*;
(
  input  chan_t     n,
  input  chan_t     w,
  input  chan_t     nw,
  input  pred_sel_t sel,
  output chan_t     pred
);

  logic signed [CH_W+1:0] sn;
  logic signed [CH_W+1:0] sw;
  logic signed [CH_W+1:0] snw;
  logic signed [CH_W+1:0] d_wnw;
  logic signed [CH_W+1:0] d_nnw;
  logic signed [CH_W+1:0] h_wnw;
  logic signed [CH_W+1:0] h_nnw;
  logic signed [CH_W+1:0] grad;
  logic signed [CH_W+1:0] sum_nw;
  logic        [CH_W-1:0] hi;
  logic        [CH_W-1:0] lo;
  logic signed [CH_W+1:0] p;

  always_comb begin
    sn     = $signed({2'b00, n});
    sw     = $signed({2'b00, w});
    snw    = $signed({2'b00, nw});
    d_wnw  = sw - snw;
    d_nnw  = sn - snw;
    // halve toward zero
    h_wnw  = (d_wnw + (d_wnw[CH_W+1] ? 10'sd1 : 10'sd0)) >>> 1;
    h_nnw  = (d_nnw + (d_nnw[CH_W+1] ? 10'sd1 : 10'sd0)) >>> 1;
    grad   = sn + sw - snw;
    sum_nw = sn + sw;
    hi     = (n > w) ? n : w;
    lo     = (n > w) ? w : n;
    unique case (sel)
      PRED_W:      p = sw;
      PRED_N:      p = sn;
      PRED_NW:     p = snw;
      PRED_GRAD:   p = grad;
      PRED_N_HALF: p = sn + h_wnw;
      PRED_W_HALF: p = sw + h_nnw;
      PRED_AVG:    p = sum_nw >>> 1;
      PRED_MED: begin
        if (nw >= hi) begin
          p = $signed({2'b00, lo});
        end else if (nw <= lo) begin
          p = $signed({2'b00, hi});
        end else begin
          p = grad;
        end
      end
      default:     p = sw;
    endcase
    pred = p[CH_W-1:0];
  end

endmodule

// File: src/lpr_line_buf.sv
// ----------------------------------------------------------------------------
// lpr_line_buf
// Previous-row pixel store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lpr_line_buf
  import lpr_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [PIX_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_data
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/lpr_checker.sv
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks of item flow through the residual block.
// ----------------------------------------------------------------------------
module lpr_checker
  import lpr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [PIX_W-1:0]  m_tdata
);

  logic [2:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 3'((s_tvalid && s_tready) ? 1 : 0)
                           - 3'((m_tvalid && m_tready) ? 1 : 0);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> inflight != 3'd0)
    else $error("result without accepted item");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'd2)
    else $error("more items held than stages");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    inflight == 3'd0 |-> s_tready)
    else $error("empty block refuses items");

endmodule

bind lossless_predictor_residual_top lpr_checker u_lpr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: test/lossless_predictor_residual_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lossless_predictor_residual_top_tb
// Drives RGB raster items through the residual block and compares every
// result, channel by channel, with a local raster predictor. A short table
// walks every predictor and the row-width corner cases. Random frames follow
// with random widths, selections and idle/stall patterns on both buses.
// ----------------------------------------------------------------------------
module lossless_predictor_residual_top_tb;
  import lpr_pkg::*;

  localparam int unsigned LINE_DEPTH = 4096;
  localparam int unsigned RAND_ITEMS = 1524;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PLAN_LEN = 38;

  typedef enum logic {STEP_PIX, STEP_CFG} step_kind_t;

  typedef struct {
    step_kind_t        kind;
    cfg_reg_t          addr;
    logic [CFG_DW-1:0] value;
    logic [PIX_W-1:0]  pix;    // blue, green, red from the top byte down
    logic              fs;
    logic              typed;
    logic [PIX_W-1:0]  want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [PIX_W-1:0]  s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [PIX_W-1:0]  m_tdata;
  logic              cfg_we = 1'b0;
  cfg_reg_t          cfg_addr = REG_ROW_WIDTH;
  logic [CFG_DW-1:0] cfg_data = '0;

  int unsigned src_idle_pct = 18;
  int unsigned sink_idle_pct = 61;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  logic [PIX_W-1:0] residual_q [$];

  // raster predictor state
  logic [PIX_W-1:0] row_buf [LINE_DEPTH];
  bit               row_known [LINE_DEPTH];
  logic [PIX_W-1:0] left_pix = '0;
  logic [PIX_W-1:0] upleft_pix = '0;
  int unsigned      col_pos = 0;
  bit               first_row = 1'b1;
  int unsigned      width_reg = LINE_DEPTH;
  pred_sel_t        sel_reg = PRED_MED;

  plan_row_t directed_plan [PLAN_LEN] = '{
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h8000FF, 1'b0, 1'b1, 24'h8000FF},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h7FFF00, 1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_ROW_WIDTH,   13'd0,            24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h563412, 1'b1, 1'b1, 24'h563412},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'hFFFF00, 1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_ROW_WIDTH,   13'd2,            24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_PRED_SELECT, 13'(PRED_W),      24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h80F010, 1'b1, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h7F00FF, 1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h01FE40, 1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'hC03399, 1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_PRED_SELECT, 13'(PRED_N),      24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'hFF0001, 1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h00FF7E, 1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_PRED_SELECT, 13'(PRED_NW),     24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h807F01, 1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h3CC3AA, 1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_PRED_SELECT, 13'(PRED_GRAD),   24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h0102FE, 1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'hFE0201, 1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_PRED_SELECT, 13'(PRED_N_HALF), 24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h11EE77, 1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'hE0111F, 1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_PRED_SELECT, 13'(PRED_W_HALF), 24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h55AA00, 1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h0F0FF0, 1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_PRED_SELECT, 13'(PRED_AVG),    24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'hFFFFFF, 1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h000000, 1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_PRED_SELECT, 13'(PRED_MED),    24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h9C27D4, 1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h40B0E0, 1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_ROW_WIDTH,   13'd8191,         24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h00FF80, 1'b1, 1'b1, 24'h00FF80},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h5A5A5A, 1'b0, 1'b0, 24'h0},
    '{STEP_CFG, REG_ROW_WIDTH,   13'd1,            24'h0,      1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'hA5A5A5, 1'b0, 1'b0, 24'h0},
    '{STEP_PIX, REG_ROW_WIDTH,   13'd0,            24'h123456, 1'b0, 1'b0, 24'h0}
  };

  lossless_predictor_residual_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // red_in, green_in, blue_in
    .s_tuser  (s_tuser),   // frame_start
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // red_residual, green_residual, blue_residual
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [CH_W-1:0] predict_chan(int n, int w, int nw, pred_sel_t sel);
    int hi;
    int lo;
    int p;
    hi = (n > w) ? n : w;
    lo = (n > w) ? w : n;
    case (sel)
      PRED_W:      p = w;
      PRED_N:      p = n;
      PRED_NW:     p = nw;
      PRED_GRAD:   p = n + w - nw;
      PRED_N_HALF: p = n + (w - nw) / 2;
      PRED_W_HALF: p = w + (n - nw) / 2;
      PRED_AVG:    p = (n + w) / 2;
      default: begin
        if (nw >= hi) p = lo;
        else if (nw <= lo) p = hi;
        else p = n + w - nw;
      end
    endcase
    return p[CH_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] advance_raster(logic [PIX_W-1:0] pix, logic fs);
    int unsigned span;
    int unsigned col;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] n_pix;
    logic [PIX_W-1:0] w_pix;
    logic [PIX_W-1:0] nw_pix;
    logic [PIX_W-1:0] res;
    span = (width_reg == 0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
    if (fs) begin
      col_pos = 0;
      first_row = 1'b1;
    end
    col = col_pos;
    above = row_buf[col];
    n_pix = first_row ? '0 : above;
    w_pix = (col == 0) ? '0 : left_pix;
    nw_pix = (col == 0 || first_row) ? '0 : upleft_pix;
    for (int k = 0; k < 3; k++) begin
      res[k*CH_W +: CH_W] = pix[k*CH_W +: CH_W] -
          predict_chan(int'(n_pix[k*CH_W +: CH_W]), int'(w_pix[k*CH_W +: CH_W]),
                       int'(nw_pix[k*CH_W +: CH_W]), sel_reg);
    end
    upleft_pix = above;
    row_buf[col] = pix;
    row_known[col] = 1'b1;
    left_pix = pix;
    if (col + 1 >= span) begin
      col_pos = 0;
      first_row = 1'b0;
    end else begin
      col_pos = col + 1;
    end
    return res;
  endfunction

  task automatic write_reg(input cfg_reg_t addr, input logic [CFG_DW-1:0] value);
    s_tvalid <= 1'b0;
    while (residual_q.size() != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value;
    if (addr == REG_ROW_WIDTH) width_reg = 32'(value);
    else sel_reg = pred_sel_t'(value[PS_W-1:0]);
    @(negedge clk);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs, input logic typed,
                            input logic [PIX_W-1:0] want);
    logic [PIX_W-1:0] res;
    logic start;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    // restart the frame rather than read a line-buffer entry never written
    start = fs || (!first_row && !row_known[col_pos]);
    res = advance_raster(pix, start);
    residual_q.push_back(typed ? want : res);
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tuser <= start;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic [PIX_W-1:0] exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (residual_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected item: r=%h g=%h b=%h", m_tdata[7:0], m_tdata[15:8],
                   m_tdata[23:16]);
      end else begin
        exp_res = residual_q.pop_front();
        if (m_tdata[7:0] !== exp_res[7:0] || m_tdata[15:8] !== exp_res[15:8] ||
            m_tdata[23:16] !== exp_res[23:16]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("residual mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                     exp_res[7:0], exp_res[15:8], exp_res[23:16],
                     m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [PIX_W-1:0] pix;
    logic [CFG_DW-1:0] span;
    sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == STEP_CFG)
        write_reg(directed_plan[i].addr, directed_plan[i].value);
      else
        send_pixel(directed_plan[i].pix, directed_plan[i].fs, directed_plan[i].typed,
                   directed_plan[i].want);
    end

    while (sent < RAND_ITEMS) begin
      if (sent < RAND_ITEMS / 3) begin
        src_idle_pct = 18;
        sink_idle_pct = 61;
      end else if (sent < 2 * RAND_ITEMS / 3) begin
        src_idle_pct = 61;
        sink_idle_pct = 18;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 5) span = '0;
      else if (pick < 8) span = CFG_DW'(LINE_DEPTH);
      else if (pick < 10) span = CFG_DW'($urandom_range(LINE_DEPTH + 1, 8191));
      else if (pick < 16) span = CFG_DW'(1);
      else if (pick < 70) span = CFG_DW'($urandom_range(2, 8));
      else span = CFG_DW'($urandom_range(9, 40));
      if ($urandom_range(2) != 0) write_reg(REG_ROW_WIDTH, span);
      if ($urandom_range(2) != 0) write_reg(REG_PRED_SELECT, CFG_DW'($urandom_range(7)));
      len = $urandom_range(10, 60);
      for (int j = 0; j < len && sent < RAND_ITEMS; j++) begin
        if ($urandom_range(9) < 4) begin
          for (int k = 0; k < 3; k++)
            pix[k*CH_W +: CH_W] = left_pix[k*CH_W +: CH_W] + CH_W'($urandom_range(6)) - 8'd3;
        end else begin
          pix = PIX_W'($urandom);
        end
        send_pixel(pix, $urandom_range(49) == 0, 1'b0, '0);
        sent++;
      end
    end

    s_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    while (residual_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && residual_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
